/* design/mdiv_pkg.sv */
`default_nettype none
package mdiv_pkg;

	localparam int WORD_W = 32;

endpackage
`default_nettype wire

/* design/mdiv_if.sv */
`default_nettype none
interface mdiv_op_if import mdiv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] dividend_word;
	logic [WORD_W-1:0] divisor_word;
	logic              final_word;

	modport source (output valid, dividend_word, divisor_word, final_word, input ready);
	modport sink   (input valid, dividend_word, divisor_word, final_word, output ready);
endinterface

interface mdiv_res_if import mdiv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] quotient_word;
	logic [WORD_W-1:0] remainder_word;
	logic              zero_divisor;
	logic              last_out;

	modport source (output valid, quotient_word, remainder_word, zero_divisor, last_out,
		input ready);
	modport sink   (input valid, quotient_word, remainder_word, zero_divisor, last_out,
		output ready);
endinterface
`default_nettype wire

/* design/mdiv_shift_sub.sv */
`default_nettype none
module mdiv_shift_sub import mdiv_pkg::*; #(
	parameter int N = 256
) (
	input  wire logic [N-1:0] rem,
	input  wire logic         in_bit,
	input  wire logic [N-1:0] div,
	output logic      [N-1:0] rem_next,
	output logic              q_bit
);

	logic [N:0]   shifted;
	logic [N+1:0] diff;

	// one restoring step: shift in the next dividend bit, trial subtract
	assign shifted  = {rem, in_bit};
	assign diff     = {1'b0, shifted} - {2'b00, div};
	assign q_bit    = ~diff[N+1];
	assign rem_next = q_bit ? diff[N-1:0] : shifted[N-1:0];

endmodule
`default_nettype wire

/* design/multiword_divider_core.sv */
`default_nettype none
// Unsigned multi-word divider. Operand word pairs arrive least significant first, one per
// item, and the item flagged final_word starts the division; pairs beyond WORDS are dropped
// and words never sent count as zero. Each operand item is taken as soon as it is offered
// in the load phase. The division then runs one quotient bit per cycle through a single
// WORDS*32-bit shift-subtract unit, and no item is accepted meanwhile; a zero divisor skips
// this phase. WORDS result items follow, one per cycle while the sink is ready, least
// significant first, the last one flagged by last_out. The block accepts the next dividend
// only after the last result item has been taken.
module multiword_divider_core import mdiv_pkg::*; #(
	parameter int WORDS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mdiv_op_if.sink   op,
	mdiv_res_if.source res
);

	localparam int N  = WORDS * WORD_W;
	localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW = $clog2(WORDS + 1);
	localparam int BW = $clog2(N);

	localparam logic [1:0] S_LOAD = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]    state_q;
	logic [N-1:0]  dvd_q;    // dividend, turns into the quotient as bits shift in
	logic [N-1:0]  div_q;
	logic [N-1:0]  rem_q;
	logic [CW-1:0] load_idx_q;
	logic [BW-1:0] bit_cnt_q;
	logic [IW-1:0] emit_cnt_q;
	logic          zero_q;

	logic [N-1:0]  div_next;
	logic [N-1:0]  rem_next;
	logic          q_bit;
	logic          store_ok;
	logic          op_fire;
	logic          res_fire;
	logic          div_zero;
	logic          last_word;

	assign op_fire   = op.valid && op.ready;
	assign res_fire  = res.valid && res.ready;
	assign store_ok  = load_idx_q < CW'(WORDS);
	assign last_word = emit_cnt_q == IW'(WORDS - 1);

	always_comb begin
		div_next = div_q;
		if (store_ok) begin
			div_next[load_idx_q[IW-1:0]*WORD_W +: WORD_W] = op.divisor_word;
		end
	end

	assign div_zero = ~|div_next;

	mdiv_shift_sub #(.N(N)) u_step (
		.rem      (rem_q),
		.in_bit   (dvd_q[N-1]),
		.div      (div_q),
		.rem_next (rem_next),
		.q_bit    (q_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			dvd_q      <= '0;
			div_q      <= '0;
			rem_q      <= '0;
			load_idx_q <= '0;
			bit_cnt_q  <= '0;
			emit_cnt_q <= '0;
			zero_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (op_fire) begin
						if (store_ok) begin
							dvd_q[load_idx_q[IW-1:0]*WORD_W +: WORD_W] <= op.dividend_word;
							load_idx_q <= load_idx_q + 1'b1;
						end
						div_q <= div_next;
						if (op.final_word) begin
							bit_cnt_q <= BW'(N - 1);
							zero_q    <= div_zero;
							state_q   <= div_zero ? S_EMIT : S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q     <= rem_next;
					dvd_q     <= {dvd_q[N-2:0], q_bit};
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_fire) begin
						dvd_q      <= dvd_q >> WORD_W;
						rem_q      <= rem_q >> WORD_W;
						emit_cnt_q <= emit_cnt_q + 1'b1;
						if (last_word) begin
							// stores go back to zero for the next division
							dvd_q      <= '0;
							div_q      <= '0;
							rem_q      <= '0;
							load_idx_q <= '0;
							emit_cnt_q <= '0;
							zero_q     <= 1'b0;
							state_q    <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign op.ready           = state_q == S_LOAD;
	assign res.valid          = state_q == S_EMIT;
	assign res.quotient_word  = zero_q ? '0 : dvd_q[WORD_W-1:0];
	assign res.remainder_word = rem_q[WORD_W-1:0];
	assign res.zero_divisor   = zero_q;
	assign res.last_out       = last_word;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < div_q)
		else $error("partial remainder not below divisor");

	a_zero_rem: assert property (@(posedge clk) disable iff (!arst_n)
		zero_q |-> rem_q == '0)
		else $error("remainder nonzero with zero divisor");

	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		op_fire && op.final_word && !div_zero |=> state_q == S_DIV && rem_q == '0)
		else $error("division did not start from a clear remainder");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire && res.last_out |=> state_q == S_LOAD && load_idx_q == '0 && div_q == '0)
		else $error("stores not cleared after last result item");

endmodule
`default_nettype wire
